### hw/rtl/atk_pkg.sv
// ----------------------------------------------------------------------------
// atk_pkg
// Types and character codes shared by the argument tokenizer files.
// ----------------------------------------------------------------------------
package atk_pkg;

  localparam int CHAR_W = 8;
  localparam int IDX_W  = 8;

  // register indexes
  localparam logic [1:0] REG_COMMENT_CHAR = 2'd0;
  localparam logic [1:0] REG_LITERAL_BS   = 2'd1;
  localparam logic [1:0] REG_FIRST_ENTRY  = 2'd2;
  localparam logic [1:0] REG_MAX_ENTRIES  = 2'd3;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5c;
  localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
  localparam logic [CHAR_W-1:0] CH_7      = 8'h37;
  localparam logic [CHAR_W-1:0] CH_9      = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UC_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UC_F   = 8'h46;
  localparam logic [CHAR_W-1:0] CH_LC_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LC_B   = 8'h62;
  localparam logic [CHAR_W-1:0] CH_LC_F   = 8'h66;
  localparam logic [CHAR_W-1:0] CH_LC_N   = 8'h6e;
  localparam logic [CHAR_W-1:0] CH_LC_R   = 8'h72;
  localparam logic [CHAR_W-1:0] CH_LC_T   = 8'h74;
  localparam logic [CHAR_W-1:0] CH_LC_V   = 8'h76;
  localparam logic [CHAR_W-1:0] CH_LC_X   = 8'h78;

  // control codes produced by escapes
  localparam logic [CHAR_W-1:0] CC_BEL = 8'h07;
  localparam logic [CHAR_W-1:0] CC_BS  = 8'h08;
  localparam logic [CHAR_W-1:0] CC_VT  = 8'h0b;
  localparam logic [CHAR_W-1:0] CC_FF  = 8'h0c;

  // digit value offsets and escape value limits
  localparam logic [CHAR_W-1:0] HEX_LC_BIAS = CH_LC_A - 8'd10;
  localparam logic [CHAR_W-1:0] HEX_UC_BIAS = CH_UC_A - 8'd10;
  localparam logic [CHAR_W-1:0] HEX_LIMIT   = 8'd15;
  localparam logic [CHAR_W-1:0] OCT_LIMIT   = 8'hff >> 3;

  typedef struct packed {
    logic [CHAR_W-1:0] comment_char;
    logic              literal_backslash;
    logic [IDX_W-1:0]  first_entry;
    logic [IDX_W-1:0]  max_entries;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    comment_char:      8'd59,
    literal_backslash: 1'b0,
    first_entry:       8'd0,
    max_entries:       8'd64
  };

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              char_valid;
    logic              token_end;
    logic [IDX_W-1:0]  token_index;
    logic              text_done;
    logic [IDX_W-1:0]  arg_count;
    logic              last;
  } out_item_t;

  // results of one byte: up to two items and their count
  typedef struct packed {
    out_item_t [1:0] res;
    logic [1:0]      n;
  } step_res_t;

endpackage

### hw/rtl/atk_if.sv
// ----------------------------------------------------------------------------
// atk_if
// Valid/ready channels of the argument tokenizer: text bytes in, results out.
// ----------------------------------------------------------------------------
interface atk_char_if;
  logic               valid;
  logic               ready;
  atk_pkg::in_item_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface atk_result_if;
  logic               valid;
  logic               ready;
  atk_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/argument_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// argument_tokenizer_unit
// Splits a byte stream into command-line arguments with quoting, escapes and
// comments; reports the argument count at the terminating zero byte.
//
//   port      dir  moves                         accepted when
//   chars     in   one text byte (char_code)     valid && ready
//   results   out  one result item               valid && ready
//   cfg_*     in   register write (index, data)  cfg_we
//
// one text byte per cycle; its results land in a four-entry queue the next cycle
// a byte that yields two results drains at one result per cycle while results.ready
// chars.ready is high while the queue holds two items or fewer
// synchronous reset: parse state cleared, registers back to defaults, queue empty
// ----------------------------------------------------------------------------
module argument_tokenizer_unit (
  input  logic                          clk,
  input  logic                          rst,
  atk_char_if.sink                      chars,
  atk_result_if.source                  results,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [atk_pkg::CHAR_W-1:0]    cfg_data
);

  atk_pkg::cfg_t      cfg;
  atk_pkg::step_res_t step;
  logic               accept;
  logic               fe_load;
  logic               room;
  logic               pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= atk_pkg::CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        atk_pkg::REG_COMMENT_CHAR: cfg.comment_char      <= cfg_data;
        atk_pkg::REG_LITERAL_BS:   cfg.literal_backslash <= cfg_data[0];
        atk_pkg::REG_FIRST_ENTRY:  cfg.first_entry       <= cfg_data;
        atk_pkg::REG_MAX_ENTRIES:  cfg.max_entries       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign fe_load     = cfg_we && (cfg_index == atk_pkg::REG_FIRST_ENTRY);
  assign chars.ready = room;
  assign accept      = chars.valid && room;
  assign pop         = results.valid && results.ready;

  atk_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .char_code (chars.payload.char_code),
    .cfg       (cfg),
    .fe_load   (fe_load),
    .fe_value  (cfg_data),
    .step      (step)
  );

  atk_res_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .wr        (step),
    .pop       (pop),
    .head      (results.payload),
    .not_empty (results.valid),
    .room      (room)
  );

  // zero byte always yields a result
  assert property (@(posedge clk) disable iff (rst)
    accept && (chars.payload.char_code == atk_pkg::CH_NUL) |-> step.n != 2'd0)
    else $error("zero byte produced no result");

  // only the second of two results carries last
  assert property (@(posedge clk) disable iff (rst)
    accept && (step.n == 2'd2) |-> !step.res[0].last && step.res[1].last)
    else $error("last marker misplaced");

  // end of text closes the byte's results
  assert property (@(posedge clk) disable iff (rst)
    results.valid && results.payload.text_done |-> results.payload.last)
    else $error("text done result without last");

endmodule

### hw/rtl/atk_core.sv
// ----------------------------------------------------------------------------
// atk_core
// Parse state registers and the single-pass decode of one text byte into
// up to two result items.
// ----------------------------------------------------------------------------
module atk_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [atk_pkg::CHAR_W-1:0]     char_code,
  input  atk_pkg::cfg_t                  cfg,
  input  logic                           fe_load,
  input  logic [atk_pkg::IDX_W-1:0]      fe_value,
  output atk_pkg::step_res_t             step
);

  localparam logic [1:0] EK_NONE = 2'd0;
  localparam logic [1:0] EK_HEX  = 2'd1;
  localparam logic [1:0] EK_OCT  = 2'd2;

  typedef struct packed {
    logic                         it;
    logic                         iq;
    logic                         skip;
    logic                         bp;
    logic [1:0]                   ek;
    logic [atk_pkg::CHAR_W-1:0]   ev;
    logic [atk_pkg::IDX_W-1:0]    tc;
    logic                         lim;
  } pstate_t;

  localparam pstate_t ST_RESET = '{
    it:   1'b0,
    iq:   1'b0,
    skip: 1'b0,
    bp:   1'b0,
    ek:   EK_NONE,
    ev:   '0,
    tc:   atk_pkg::CFG_RESET.first_entry,
    lim:  1'b0
  };

  pstate_t            st;
  pstate_t            st_next;
  atk_pkg::step_res_t buf_next;

  function automatic logic is_sep(input logic [atk_pkg::CHAR_W-1:0] c);
    is_sep = (c == atk_pkg::CH_SPACE) || (c == atk_pkg::CH_TAB) ||
             (c == atk_pkg::CH_CR) || (c == atk_pkg::CH_LF);
  endfunction

  function automatic logic is_comment(input logic [atk_pkg::CHAR_W-1:0] c,
                                      input atk_pkg::cfg_t k);
    is_comment = (c == k.comment_char) && (c != atk_pkg::CH_QUOTE) &&
                 ((c != atk_pkg::CH_BSLASH) || k.literal_backslash);
  endfunction

  function automatic logic begin_token(inout pstate_t s, input atk_pkg::cfg_t k);
    begin_token = 1'b1;
    if (!s.it) begin
      if (s.tc >= k.max_entries) begin
        s.lim = 1'b1;
        begin_token = 1'b0;
      end else begin
        s.it = 1'b1;
      end
    end
  endfunction

  function automatic void emit(input pstate_t s, inout atk_pkg::step_res_t b,
                               input logic [atk_pkg::CHAR_W-1:0] ch,
                               input logic valid, input logic tend,
                               input logic tdone,
                               input logic [atk_pkg::IDX_W-1:0] count);
    atk_pkg::out_item_t r;
    r.out_char    = ch;
    r.char_valid  = valid;
    r.token_end   = tend;
    r.token_index = s.tc;
    r.text_done   = tdone;
    r.arg_count   = count;
    r.last        = 1'b0;
    case (b.n)
      2'd0: begin
        b.res[0] = r;
        b.n      = 2'd1;
      end
      2'd1: begin
        b.res[1] = r;
        b.n      = 2'd2;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void put_char(input pstate_t s, inout atk_pkg::step_res_t b,
                                   input logic [atk_pkg::CHAR_W-1:0] ch);
    emit(s, b, ch, 1'b1, 1'b0, 1'b0, '0);
  endfunction

  function automatic void end_token(inout pstate_t s, inout atk_pkg::step_res_t b);
    emit(s, b, '0, 1'b0, 1'b1, 1'b0, '0);
    s.tc = s.tc + 1'b1;
    s.it = 1'b0;
    s.iq = 1'b0;
  endfunction

  function automatic void finish_text(inout pstate_t s, inout atk_pkg::step_res_t b,
                                      input atk_pkg::cfg_t k);
    emit(s, b, '0, 1'b0, s.it, 1'b1, s.tc + {{(atk_pkg::IDX_W-1){1'b0}}, s.it});
    s.it   = 1'b0;
    s.iq   = 1'b0;
    s.skip = 1'b0;
    s.bp   = 1'b0;
    s.ek   = EK_NONE;
    s.ev   = '0;
    s.lim  = 1'b0;
    s.tc   = k.first_entry;
  endfunction

  function automatic void plain(inout pstate_t s, inout atk_pkg::step_res_t b,
                                input logic [atk_pkg::CHAR_W-1:0] c,
                                input atk_pkg::cfg_t k);
    logic go;
    go = 1'b1;
    if (!s.it) begin
      if (is_sep(c)) begin
        go = 1'b0;
      end else if (is_comment(c, k)) begin
        s.skip = 1'b1;
        go = 1'b0;
      end else begin
        go = begin_token(s, k);
      end
    end
    if (go) begin
      if (c == atk_pkg::CH_QUOTE) begin
        s.iq = ~s.iq;
      end else if (!s.iq && is_sep(c)) begin
        end_token(s, b);
      end else if (!s.iq && is_comment(c, k)) begin
        end_token(s, b);
        s.skip = 1'b1;
      end else begin
        put_char(s, b, c);
      end
    end
  endfunction

  function automatic void dispatch(inout pstate_t s, inout atk_pkg::step_res_t b,
                                   input logic [atk_pkg::CHAR_W-1:0] c,
                                   input atk_pkg::cfg_t k);
    if (c == atk_pkg::CH_NUL) begin
      finish_text(s, b, k);
    end else if (s.lim) begin
    end else if (s.skip) begin
      if ((c == atk_pkg::CH_CR) || (c == atk_pkg::CH_LF)) s.skip = 1'b0;
    end else if (c == atk_pkg::CH_BSLASH) begin
      if (!s.it && (s.tc >= k.max_entries)) s.lim = 1'b1;
      else s.bp = 1'b1;
    end else begin
      plain(s, b, c, k);
    end
  endfunction

  function automatic void decode_escape(inout pstate_t s, inout atk_pkg::step_res_t b,
                                        input logic [atk_pkg::CHAR_W-1:0] c);
    case (c)
      atk_pkg::CH_LC_A: put_char(s, b, atk_pkg::CC_BEL);
      atk_pkg::CH_LC_B: put_char(s, b, atk_pkg::CC_BS);
      atk_pkg::CH_LC_F: put_char(s, b, atk_pkg::CC_FF);
      atk_pkg::CH_LC_N: put_char(s, b, atk_pkg::CH_LF);
      atk_pkg::CH_LC_R: put_char(s, b, atk_pkg::CH_CR);
      atk_pkg::CH_LC_T: put_char(s, b, atk_pkg::CH_TAB);
      atk_pkg::CH_LC_V: put_char(s, b, atk_pkg::CC_VT);
      atk_pkg::CH_LC_X: begin
        s.ek = EK_HEX;
        s.ev = '0;
      end
      default: begin
        if ((c >= atk_pkg::CH_0) && (c <= atk_pkg::CH_7)) begin
          s.ek = EK_OCT;
          s.ev = {5'd0, c[2:0]};
        end else begin
          put_char(s, b, c);
        end
      end
    endcase
  endfunction

  function automatic void resolve_pending(inout pstate_t s, inout atk_pkg::step_res_t b,
                                          input logic [atk_pkg::CHAR_W-1:0] c,
                                          input atk_pkg::cfg_t k);
    logic ok;
    s.bp = 1'b0;
    if (c == atk_pkg::CH_QUOTE) begin
      ok = begin_token(s, k);
      if (ok) put_char(s, b, atk_pkg::CH_QUOTE);
    end else if (c == atk_pkg::CH_NUL) begin
      plain(s, b, atk_pkg::CH_BSLASH, k);
      finish_text(s, b, k);
    end else if (s.iq && !k.literal_backslash) begin
      decode_escape(s, b, c);
    end else begin
      plain(s, b, atk_pkg::CH_BSLASH, k);
      dispatch(s, b, c, k);
    end
  endfunction

  function automatic void continue_escape(inout pstate_t s, inout atk_pkg::step_res_t b,
                                          input logic [atk_pkg::CHAR_W-1:0] c,
                                          input atk_pkg::cfg_t k);
    logic                       ok;
    logic                       over;
    logic [3:0]                 d;
    logic [atk_pkg::CHAR_W-1:0] v;
    ok = 1'b0;
    d  = 4'd0;
    if (s.ek == EK_HEX) begin
      if ((c >= atk_pkg::CH_0) && (c <= atk_pkg::CH_9)) begin
        d  = c[3:0];
        ok = 1'b1;
      end else if ((c >= atk_pkg::CH_LC_A) && (c <= atk_pkg::CH_LC_F)) begin
        d  = 4'(c - atk_pkg::HEX_LC_BIAS);
        ok = 1'b1;
      end else if ((c >= atk_pkg::CH_UC_A) && (c <= atk_pkg::CH_UC_F)) begin
        d  = 4'(c - atk_pkg::HEX_UC_BIAS);
        ok = 1'b1;
      end
      v    = {s.ev[3:0], d};
      over = v > atk_pkg::HEX_LIMIT;
    end else begin
      if ((c >= atk_pkg::CH_0) && (c <= atk_pkg::CH_7)) begin
        d  = {1'b0, c[2:0]};
        ok = 1'b1;
      end
      v    = {s.ev[4:0], d[2:0]};
      over = v > atk_pkg::OCT_LIMIT;
    end
    if (ok) begin
      if (over) begin
        put_char(s, b, v);
        s.ek = EK_NONE;
        s.ev = '0;
      end else begin
        s.ev = v;
      end
    end else begin
      put_char(s, b, s.ev);
      s.ek = EK_NONE;
      s.ev = '0;
      dispatch(s, b, c, k);
    end
  endfunction

  always_comb begin
    st_next  = st;
    buf_next = '0;
    if (st.ek != EK_NONE) begin
      continue_escape(st_next, buf_next, char_code, cfg);
    end else if (st.bp) begin
      resolve_pending(st_next, buf_next, char_code, cfg);
    end else begin
      dispatch(st_next, buf_next, char_code, cfg);
    end
    case (buf_next.n)
      2'd1: buf_next.res[0].last = 1'b1;
      2'd2: buf_next.res[1].last = 1'b1;
      default: begin
      end
    endcase
  end

  assign step = buf_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RESET;
    end else if (fe_load) begin
      st.tc <= fe_value;
    end else if (accept) begin
      st <= st_next;
    end
  end

endmodule

### hw/rtl/atk_res_queue.sv
// ----------------------------------------------------------------------------
// atk_res_queue
// Four-entry result queue: takes up to two items a cycle, hands out one,
// head always at slot zero.
// ----------------------------------------------------------------------------
module atk_res_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  atk_pkg::step_res_t  wr,
  input  logic                pop,
  output atk_pkg::out_item_t  head,
  output logic                not_empty,
  output logic                room
);

  localparam int QDEPTH = 4;
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  atk_pkg::out_item_t [QDEPTH-1:0] slot;
  atk_pkg::out_item_t [QDEPTH-1:0] slot_next;
  logic [CNT_W-1:0]                count;
  logic [CNT_W-1:0]                count_next;
  logic [CNT_W-1:0]                base;
  logic [CNT_W-1:0]                add;

  always_comb begin
    base = count - {{(CNT_W-1){1'b0}}, pop};
    add  = push ? CNT_W'(wr.n) : '0;
    for (int i = 0; i < QDEPTH - 1; i++) begin
      slot_next[i] = pop ? slot[i+1] : slot[i];
    end
    slot_next[QDEPTH-1] = slot[QDEPTH-1];
    for (int i = 0; i < QDEPTH; i++) begin
      if (push && (wr.n != 2'd0) && (base == CNT_W'(i))) slot_next[i] = wr.res[0];
      if (push && (wr.n == 2'd2) && (base + 1'b1 == CNT_W'(i))) slot_next[i] = wr.res[1];
    end
    count_next = base + add;
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  assign head      = slot[0];
  assign not_empty = count != '0;
  assign room      = count <= CNT_W'(QDEPTH - 2);

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for argument_tokenizer_unit. A short table of directed bytes
// (quoting, escapes, comments, end of text) is followed by random texts under
// nine register settings and several idle/stall patterns. Every accepted
// result is checked field by field, for typed table rows against the row's item,
// else against an in-bench predictor of the splitter, which tracks its own copy of the parse state and registers.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {NUM_NONE, NUM_HEX, NUM_OCT} num_kind_t;
  typedef enum logic [1:0] {PACE_FREE, PACE_SRC, PACE_SNK, PACE_BOTH} pace_t;

  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 8;

  typedef struct packed {
    logic [atk_pkg::CHAR_W-1:0] c;
    logic                       typed;
    atk_pkg::out_item_t         want;
  } stim_row_t;

  typedef struct packed {
    pace_t                      pace;
    logic [atk_pkg::CHAR_W-1:0] cmt;
    logic                       lit;
    logic [atk_pkg::IDX_W-1:0]  base;
    logic [atk_pkg::IDX_W-1:0]  cap;
    int                         budget;
  } phase_t;

  localparam atk_pkg::out_item_t NO_WANT = '0;

  localparam int DIR_N = 29;
  localparam stim_row_t DIR_TAB [DIR_N] = '{
    '{atk_pkg::CH_NUL,    1'b1, '{8'h00, 1'b0, 1'b0, 8'd0, 1'b1, 8'd0, 1'b1}},
    '{8'h61,              1'b1, '{8'h61, 1'b1, 1'b0, 8'd0, 1'b0, 8'd0, 1'b1}},
    '{8'hff,              1'b1, '{8'hff, 1'b1, 1'b0, 8'd0, 1'b0, 8'd0, 1'b1}},
    '{atk_pkg::CH_TAB,    1'b1, '{8'h00, 1'b0, 1'b1, 8'd0, 1'b0, 8'd0, 1'b1}},
    '{atk_pkg::CH_QUOTE,  1'b0, NO_WANT},
    '{atk_pkg::CH_BSLASH, 1'b0, NO_WANT},
    '{atk_pkg::CH_LC_N,   1'b0, NO_WANT},
    '{atk_pkg::CH_BSLASH, 1'b0, NO_WANT},
    '{atk_pkg::CH_LC_X,   1'b0, NO_WANT},
    '{8'h34,              1'b0, NO_WANT},
    '{8'h31,              1'b0, NO_WANT},
    '{atk_pkg::CH_BSLASH, 1'b0, NO_WANT},
    '{atk_pkg::CH_LC_X,   1'b0, NO_WANT},
    '{8'h67,              1'b0, NO_WANT},
    '{atk_pkg::CH_BSLASH, 1'b0, NO_WANT},
    '{atk_pkg::CH_7,      1'b0, NO_WANT},
    '{atk_pkg::CH_7,      1'b0, NO_WANT},
    '{atk_pkg::CH_BSLASH, 1'b0, NO_WANT},
    '{atk_pkg::CH_QUOTE,  1'b0, NO_WANT},
    '{atk_pkg::CH_QUOTE,  1'b0, NO_WANT},
    '{8'h3b,              1'b0, NO_WANT},
    '{atk_pkg::CH_LF,     1'b0, NO_WANT},
    '{atk_pkg::CH_QUOTE,  1'b0, NO_WANT},
    '{atk_pkg::CH_BSLASH, 1'b0, NO_WANT},
    '{atk_pkg::CH_LC_X,   1'b0, NO_WANT},
    '{8'h35,              1'b0, NO_WANT},
    '{atk_pkg::CH_NUL,    1'b0, NO_WANT},
    '{atk_pkg::CH_BSLASH, 1'b0, NO_WANT},
    '{atk_pkg::CH_NUL,    1'b0, NO_WANT}
  };

  localparam int N_PH = 9;
  localparam phase_t PHASES [N_PH] = '{
    '{PACE_FREE, 8'd59,              1'b0, 8'd0,   8'd64,  175},
    '{PACE_SRC,  8'h23,              1'b1, 8'd250, 8'd255, 175},
    '{PACE_SNK,  atk_pkg::CH_SPACE,  1'b0, 8'd0,   8'd3,   175},
    '{PACE_BOTH, atk_pkg::CH_QUOTE,  1'b1, 8'd7,   8'd200, 175},
    '{PACE_FREE, atk_pkg::CH_BSLASH, 1'b1, 8'd0,   8'd64,  175},
    '{PACE_SNK,  atk_pkg::CH_BSLASH, 1'b0, 8'd255, 8'd0,   40},
    '{PACE_BOTH, 8'h00,              1'b0, 8'd100, 8'd130, 175},
    '{PACE_SRC,  8'hff,              1'b1, 8'd0,   8'd255, 175},
    '{PACE_FREE, 8'd0,               1'b0, 8'd0,   8'd0,   175}
  };

  localparam logic [atk_pkg::CHAR_W-1:0] ESC_SET [8] = '{
    atk_pkg::CH_LC_A, atk_pkg::CH_LC_B, atk_pkg::CH_LC_F, atk_pkg::CH_LC_N,
    atk_pkg::CH_LC_R, atk_pkg::CH_LC_T, atk_pkg::CH_LC_V, atk_pkg::CH_BSLASH
  };
  localparam logic [atk_pkg::CHAR_W-1:0] BLANKS [4] = '{
    atk_pkg::CH_SPACE, atk_pkg::CH_TAB, atk_pkg::CH_CR, atk_pkg::CH_LF
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [atk_pkg::CHAR_W-1:0] cfg_data;

  atk_char_if   char_ch ();
  atk_result_if res_ch ();

  argument_tokenizer_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .chars     (char_ch),
    .results   (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // predictor registers and parse state
  logic [atk_pkg::CHAR_W-1:0] cmt_char;
  logic                       lit_bs;
  logic [atk_pkg::IDX_W-1:0]  first_idx;
  logic [atk_pkg::IDX_W-1:0]  max_idx;
  logic                       arg_open;
  logic                       quoted;
  logic                       in_comment;
  logic                       bs_held;
  logic                       full_stop;
  num_kind_t                  num_kind;
  logic [atk_pkg::CHAR_W-1:0] num_val;
  logic [atk_pkg::IDX_W-1:0]  arg_idx;

  atk_pkg::out_item_t step_q[$];
  atk_pkg::out_item_t want_q[$];
  logic [atk_pkg::CHAR_W-1:0] text_q[$];

  stim_row_t offer;
  logic char_took = 1'b0;
  bit   hold_go = 1'b0;
  int   src_pct = 0;
  int   snk_pct = 0;
  int   n_fail = 0;
  int   n_bytes = 0;
  int   n_checked = 0;
  int   n_texts = 0;
  int   n_args = 0;

  function automatic void add_result(logic [atk_pkg::CHAR_W-1:0] ch, logic v, logic te,
                                     logic td, logic [atk_pkg::IDX_W-1:0] cnt);
    atk_pkg::out_item_t r;
    if (step_q.size() >= 2) return;
    r = '{out_char: ch, char_valid: v, token_end: te, token_index: arg_idx,
          text_done: td, arg_count: cnt, last: 1'b0};
    step_q.push_back(r);
  endfunction

  function automatic logic is_blank(logic [atk_pkg::CHAR_W-1:0] c);
    return c == atk_pkg::CH_SPACE || c == atk_pkg::CH_TAB ||
           c == atk_pkg::CH_CR || c == atk_pkg::CH_LF;
  endfunction

  function automatic logic is_cmt(logic [atk_pkg::CHAR_W-1:0] c);
    if (c != cmt_char || c == atk_pkg::CH_QUOTE) return 1'b0;
    return c != atk_pkg::CH_BSLASH || lit_bs;
  endfunction

  function automatic logic open_arg();
    if (arg_open) return 1'b1;
    if (arg_idx >= max_idx) begin
      full_stop = 1'b1;
      return 1'b0;
    end
    arg_open = 1'b1;
    return 1'b1;
  endfunction

  function automatic void emit_byte(logic [atk_pkg::CHAR_W-1:0] c);
    add_result(c, 1'b1, 1'b0, 1'b0, '0);
  endfunction

  function automatic void close_arg();
    add_result('0, 1'b0, 1'b1, 1'b0, '0);
    arg_idx = arg_idx + 1'b1;
    arg_open = 1'b0;
    quoted = 1'b0;
  endfunction

  function automatic void close_text();
    add_result('0, 1'b0, arg_open, 1'b1,
               arg_idx + {{(atk_pkg::IDX_W-1){1'b0}}, arg_open});
    arg_open = 1'b0;
    quoted = 1'b0;
    in_comment = 1'b0;
    bs_held = 1'b0;
    num_kind = NUM_NONE;
    num_val = '0;
    full_stop = 1'b0;
    arg_idx = first_idx;
  endfunction

  function automatic void handle_plain(logic [atk_pkg::CHAR_W-1:0] c);
    if (!arg_open) begin
      if (is_blank(c)) return;
      if (is_cmt(c)) begin
        in_comment = 1'b1;
        return;
      end
      if (!open_arg()) return;
    end
    if (c == atk_pkg::CH_QUOTE) begin
      quoted = !quoted;
      return;
    end
    if (!quoted) begin
      if (is_blank(c)) begin
        close_arg();
        return;
      end
      if (is_cmt(c)) begin
        close_arg();
        in_comment = 1'b1;
        return;
      end
    end
    emit_byte(c);
  endfunction

  function automatic void handle_byte(logic [atk_pkg::CHAR_W-1:0] c);
    if (c == atk_pkg::CH_NUL) begin
      close_text();
      return;
    end
    if (full_stop) return;
    if (in_comment) begin
      if (c == atk_pkg::CH_CR || c == atk_pkg::CH_LF) in_comment = 1'b0;
      return;
    end
    if (c == atk_pkg::CH_BSLASH) begin
      if (!arg_open && arg_idx >= max_idx) begin
        full_stop = 1'b1;
        return;
      end
      bs_held = 1'b1;
      return;
    end
    handle_plain(c);
  endfunction

  function automatic void decode_esc(logic [atk_pkg::CHAR_W-1:0] c);
    case (c)
      atk_pkg::CH_LC_A: emit_byte(atk_pkg::CC_BEL);
      atk_pkg::CH_LC_B: emit_byte(atk_pkg::CC_BS);
      atk_pkg::CH_LC_F: emit_byte(atk_pkg::CC_FF);
      atk_pkg::CH_LC_N: emit_byte(atk_pkg::CH_LF);
      atk_pkg::CH_LC_R: emit_byte(atk_pkg::CH_CR);
      atk_pkg::CH_LC_T: emit_byte(atk_pkg::CH_TAB);
      atk_pkg::CH_LC_V: emit_byte(atk_pkg::CC_VT);
      atk_pkg::CH_LC_X: begin
        num_kind = NUM_HEX;
        num_val = '0;
      end
      default: begin
        if (c >= atk_pkg::CH_0 && c <= atk_pkg::CH_7) begin
          num_kind = NUM_OCT;
          num_val = c - atk_pkg::CH_0;
        end else begin
          emit_byte(c);
        end
      end
    endcase
  endfunction

  function automatic void settle_bs(logic [atk_pkg::CHAR_W-1:0] c);
    bs_held = 1'b0;
    if (c == atk_pkg::CH_QUOTE) begin
      if (open_arg()) emit_byte(atk_pkg::CH_QUOTE);
      return;
    end
    if (c == atk_pkg::CH_NUL) begin
      handle_plain(atk_pkg::CH_BSLASH);
      close_text();
      return;
    end
    if (quoted && !lit_bs) begin
      decode_esc(c);
      return;
    end
    handle_plain(atk_pkg::CH_BSLASH);
    handle_byte(c);
  endfunction

  function automatic void extend_num(logic [atk_pkg::CHAR_W-1:0] c);
    logic [atk_pkg::CHAR_W-1:0] d;
    logic ok;
    int unsigned acc;
    d = '0;
    ok = 1'b0;
    if (num_kind == NUM_HEX) begin
      if (c >= atk_pkg::CH_0 && c <= atk_pkg::CH_9) begin
        d = c - atk_pkg::CH_0;
        ok = 1'b1;
      end else if (c >= atk_pkg::CH_LC_A && c <= atk_pkg::CH_LC_F) begin
        d = c - atk_pkg::HEX_LC_BIAS;
        ok = 1'b1;
      end else if (c >= atk_pkg::CH_UC_A && c <= atk_pkg::CH_UC_F) begin
        d = c - atk_pkg::HEX_UC_BIAS;
        ok = 1'b1;
      end
    end else if (c >= atk_pkg::CH_0 && c <= atk_pkg::CH_7) begin
      d = c - atk_pkg::CH_0;
      ok = 1'b1;
    end
    if (ok) begin
      acc = num_val * ((num_kind == NUM_HEX) ? 16 : 8) + d;
      num_val = atk_pkg::CHAR_W'(acc);
      if (num_val > ((num_kind == NUM_HEX) ? atk_pkg::HEX_LIMIT : atk_pkg::OCT_LIMIT)) begin
        emit_byte(num_val);
        num_kind = NUM_NONE;
        num_val = '0;
      end
      return;
    end
    emit_byte(num_val);
    num_kind = NUM_NONE;
    num_val = '0;
    handle_byte(c);
  endfunction

  function automatic void predict_char(logic [atk_pkg::CHAR_W-1:0] c);
    step_q.delete();
    if (num_kind != NUM_NONE) extend_num(c);
    else if (bs_held) settle_bs(c);
    else handle_byte(c);
    if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
  endfunction

  function automatic void reset_model();
    cmt_char = atk_pkg::CFG_RESET.comment_char;
    lit_bs = atk_pkg::CFG_RESET.literal_backslash;
    first_idx = atk_pkg::CFG_RESET.first_entry;
    max_idx = atk_pkg::CFG_RESET.max_entries;
    arg_open = 1'b0;
    quoted = 1'b0;
    in_comment = 1'b0;
    bs_held = 1'b0;
    full_stop = 1'b0;
    num_kind = NUM_NONE;
    num_val = '0;
    arg_idx = atk_pkg::CFG_RESET.first_entry;
  endfunction

  function automatic void apply_reg(logic [1:0] idx, logic [atk_pkg::CHAR_W-1:0] data);
    case (idx)
      atk_pkg::REG_COMMENT_CHAR: cmt_char = data;
      atk_pkg::REG_LITERAL_BS:   lit_bs = data[0];
      atk_pkg::REG_FIRST_ENTRY: begin
        first_idx = data;
        arg_idx = data;
      end
      atk_pkg::REG_MAX_ENTRIES:  max_idx = data;
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [7:0] e, logic [7:0] a);
    if (a !== e) begin
      $error("%s: expected 0x%02h, got 0x%02h", name, e, a);
      n_fail++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    atk_pkg::out_item_t want;
    atk_pkg::out_item_t got;
    char_took <= char_ch.valid && char_ch.ready;
    if (rst) begin
      reset_model();
      want_q.delete();
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got = res_ch.payload;
        if (want_q.size() == 0) begin
          $error("result with no request waiting: %h", got);
          n_fail++;
        end else begin
          want = want_q.pop_front();
          n_checked++;
          if (want.text_done) n_texts++;
          if (want.token_end) n_args++;
          check_field("out_char", want.out_char, got.out_char);
          check_field("char_valid", want.char_valid, got.char_valid);
          check_field("token_end", want.token_end, got.token_end);
          check_field("token_index", want.token_index, got.token_index);
          check_field("text_done", want.text_done, got.text_done);
          check_field("arg_count", want.arg_count, got.arg_count);
          check_field("last", want.last, got.last);
        end
      end
      if (cfg_we) apply_reg(cfg_index, cfg_data);
      if (char_ch.valid && char_ch.ready) begin
        predict_char(char_ch.payload.char_code);
        n_bytes++;
        if (offer.typed) want_q.push_back(offer.want);
        else foreach (step_q[i]) want_q.push_back(step_q[i]);
      end
    end
  end

  // receiver: random stalls plus one long hold-off on request
  initial begin : receiver
    int hold_left;
    bit hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_used) begin
        hold_left = HOLD_CYCLES;
        hold_used = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= snk_pct);
      end
    end
  end

  function automatic void set_pace(pace_t p);
    case (p)
      PACE_SRC:  begin src_pct = 81; snk_pct = 0;  end
      PACE_SNK:  begin src_pct = 0;  snk_pct = 81; end
      PACE_BOTH: begin src_pct = 9;  snk_pct = 9;  end
      default:   begin src_pct = 0;  snk_pct = 0;  end
    endcase
  endfunction

  function automatic void put(logic [atk_pkg::CHAR_W-1:0] c);
    text_q.push_back(c);
  endfunction

  function automatic logic [atk_pkg::CHAR_W-1:0] word_char();
    logic [atk_pkg::CHAR_W-1:0] c;
    do c = atk_pkg::CHAR_W'($urandom_range(8'h21, 8'hff));
    while (c == atk_pkg::CH_QUOTE || c == atk_pkg::CH_BSLASH);
    return c;
  endfunction

  function automatic logic [atk_pkg::CHAR_W-1:0] hex_char();
    int unsigned k;
    k = $urandom_range(21);
    if (k < 10) return atk_pkg::CHAR_W'(atk_pkg::CH_0 + k);
    if (k < 16) return atk_pkg::CHAR_W'(atk_pkg::CH_LC_A + k - 10);
    return atk_pkg::CHAR_W'(atk_pkg::CH_UC_A + k - 16);
  endfunction

  function automatic void quoted_piece();
    case ($urandom_range(9))
      0, 1, 2, 3: put(word_char());
      4: begin
        put(atk_pkg::CH_BSLASH);
        put(ESC_SET[$urandom_range(7)]);
      end
      5: begin
        put(atk_pkg::CH_BSLASH);
        put(atk_pkg::CH_LC_X);
        repeat ($urandom_range(0, 3)) put(hex_char());
      end
      6: begin
        put(atk_pkg::CH_BSLASH);
        repeat ($urandom_range(1, 3))
          put(atk_pkg::CHAR_W'(atk_pkg::CH_0 + $urandom_range(7)));
      end
      7: begin
        put(atk_pkg::CH_BSLASH);
        put(atk_pkg::CH_QUOTE);
      end
      8: begin
        put(atk_pkg::CH_BSLASH);
        put(atk_pkg::CHAR_W'($urandom_range(1, 255)));
      end
      default: put(BLANKS[$urandom_range(3)]);
    endcase
  endfunction

  // one zero-terminated text: mostly well-formed arguments, some raw noise
  function automatic void build_text();
    text_q.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 24)) put(atk_pkg::CHAR_W'($urandom_range(1, 255)));
      put(atk_pkg::CH_NUL);
      return;
    end
    repeat ($urandom_range(0, 7)) begin
      repeat ($urandom_range(1, 2)) put(BLANKS[$urandom_range(3)]);
      case ($urandom_range(7))
        0, 1, 2: repeat ($urandom_range(1, 6)) put(word_char());
        3, 4: begin
          put(atk_pkg::CH_QUOTE);
          repeat ($urandom_range(0, 6)) quoted_piece();
          if ($urandom_range(7) != 0) put(atk_pkg::CH_QUOTE);
        end
        5: begin
          put(atk_pkg::CH_QUOTE);
          put(atk_pkg::CH_QUOTE);
        end
        6: begin
          put(atk_pkg::CH_BSLASH);
          put(atk_pkg::CH_QUOTE);
          repeat ($urandom_range(0, 3)) put(word_char());
        end
        default: begin
          put(cmt_char);
          repeat ($urandom_range(0, 5)) put(word_char());
          put($urandom_range(1) ? atk_pkg::CH_LF : atk_pkg::CH_CR);
        end
      endcase
    end
    if ($urandom_range(3) == 0) put(atk_pkg::CH_BSLASH);
    put(atk_pkg::CH_NUL);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic push_byte(input stim_row_t row);
    if ($urandom_range(99) < src_pct) begin
      char_ch.valid <= 1'b0;
      do @(negedge clk);
      while ($urandom_range(99) < src_pct);
    end
    offer = row;
    char_ch.valid <= 1'b1;
    char_ch.payload <= '{char_code: row.c};
    @(negedge clk);
    while (!char_took) @(negedge clk);
  endtask

  task automatic wait_idle();
    while (want_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_regs(input logic [atk_pkg::CHAR_W-1:0] cc, input logic lb,
                            input logic [atk_pkg::IDX_W-1:0] fe,
                            input logic [atk_pkg::IDX_W-1:0] me);
    cfg_we <= 1'b1;
    cfg_index <= atk_pkg::REG_COMMENT_CHAR;
    cfg_data <= cc;
    @(negedge clk);
    cfg_index <= atk_pkg::REG_LITERAL_BS;
    cfg_data <= {{(atk_pkg::CHAR_W-1){1'b0}}, lb};
    @(negedge clk);
    cfg_index <= atk_pkg::REG_FIRST_ENTRY;
    cfg_data <= fe;
    @(negedge clk);
    cfg_index <= atk_pkg::REG_MAX_ENTRIES;
    cfg_data <= me;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    phase_t ph;
    int sent;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    char_ch.valid = 1'b0;
    char_ch.payload = '0;
    offer = '0;
    set_pace(PACE_BOTH);
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    foreach (DIR_TAB[i]) push_byte(DIR_TAB[i]);
    char_ch.valid <= 1'b0;
    wait_idle();

    for (int p = 0; p < N_PH; p++) begin
      ph = PHASES[p];
      if (p == N_PH - 1) begin
        ph.cmt = atk_pkg::CHAR_W'($urandom_range(255));
        ph.lit = 1'($urandom_range(1));
        ph.base = atk_pkg::IDX_W'($urandom_range(0, 40));
        ph.cap = atk_pkg::IDX_W'($urandom_range(255));
      end
      set_pace(ph.pace);
      write_regs(ph.cmt, ph.lit, ph.base, ph.cap);
      if (p == 0) hold_go = 1'b1;
      sent = 0;
      while (sent < ph.budget) begin
        build_text();
        foreach (text_q[i]) push_byte('{text_q[i], 1'b0, NO_WANT});
        sent += text_q.size();
      end
      char_ch.valid <= 1'b0;
      wait_idle();
    end

    set_pace(PACE_FREE);
    wait_idle();
    repeat (2 * SETTLE) @(negedge clk);
    if (want_q.size() != 0) begin
      $error("%0d results never arrived", want_q.size());
      n_fail++;
    end
    $display("tb_top: %0d text bytes sent, %0d results checked", n_bytes, n_checked);
    $display("tb_top: %0d texts ended, %0d arguments closed, %0d register settings",
             n_texts, n_args, N_PH + 1);
    if (n_fail == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/atk_pkg.sv
hw/rtl/atk_if.sv
hw/rtl/atk_core.sv
hw/rtl/atk_res_queue.sv
hw/rtl/argument_tokenizer_unit.sv
tb/sv/tb_top.sv
